[rtl/core/xbmd_pkg.sv]
// ----------------------------------------------------------------------------
// XBM decoder package
// Shared types, widths and codes of the XBM text-to-pixel decoder.
// ----------------------------------------------------------------------------
package xbmd_pkg;

  // Configuration register file.
  localparam int CfgDataW = 13;
  localparam int CfgMaxVal = (1 << CfgDataW) - 1;
  localparam int DimCmpW = 17;
  localparam int MaxDimensionDef = 4096;

  typedef enum logic [0:0] {
    CfgWidth  = 1'b0,
    CfgHeight = 1'b1
  } xbmd_cfg_e;

  // Result coordinate widths.
  localparam int PixW = 12;
  localparam int ColOutW = PixW - 3;

  // Queue between the tokenizer and the pixel serializer.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);

  // Characters that the tokenizer recognizes.
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLowX = 8'h78;
  localparam logic [7:0] ChUpX = 8'h58;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpF = 8'h46;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowF = 8'h66;

  // Input command codes.
  localparam logic CmdChar = 1'b0;
  localparam logic CmdRestart = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
  } xbmd_in_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_x;
    logic [PixW-1:0] pixel_y;
    logic            pixel_on;
    logic            last;
    logic            image_done;
  } xbmd_out_t;

  // One decoded byte with its place in the image.
  typedef struct packed {
    logic [ColOutW-1:0] col;
    logic [PixW-1:0]    row;
    logic [7:0]         val;
    logic               done;
  } xbmd_byte_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } xbmd_qstat_t;

endpackage

[rtl/core/xbmd_front.sv]
// ----------------------------------------------------------------------------
// XBM decoder front end
// Tokenizes characters into byte values and places each byte in the image.
// ----------------------------------------------------------------------------
module xbmd_front import xbmd_pkg::*; #(
  parameter int MAX_DIMENSION = MaxDimensionDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xbmd_in_t            in_word_i,
  input  xbmd_qstat_t         q_stat_i,
  output logic                push_o,
  output xbmd_byte_t          push_byte_o
);

  localparam int EffW = (MAX_DIMENSION > CfgMaxVal) ? CfgDataW : $clog2(MAX_DIMENSION + 1);
  localparam int ColW = EffW - 3;

  typedef enum logic [4:0] {
    ModeIdle    = 5'b00001,
    ModeZero    = 5'b00010,
    ModeDec     = 5'b00100,
    ModeHex     = 5'b01000,
    ModeSwallow = 5'b10000
  } xbmd_mode_e;

  logic [CfgDataW-1:0] width_q, height_q;
  xbmd_mode_e          mode_q, mode_d;
  logic [7:0]          acc_q, acc_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [EffW-1:0]     row_q, row_d;
  logic                fin_q, fin_d;

  logic            accept;
  logic [7:0]      ch;
  logic            is_dig, is_hex;
  logic [3:0]      nib;
  logic            emit_req, nul_fin;
  logic [7:0]      emit_val;
  logic [EffW-1:0] w_eff, h_eff;
  logic [EffW-3:0] per_row;
  logic [EffW:0]   w_plus;
  logic [ColW-1:0] col1;
  logic [ColW:0]   col_next;
  logic [EffW-1:0] row1;
  logic            pos_fin, pos_push, pos_done;

  // The input side only waits on a full queue.
  assign in_stall_o = q_stat_i.full;
  assign accept = in_valid_i & ~in_stall_o;

  assign ch = in_word_i.char_code;
  assign is_dig = (ch >= ChZero) && (ch <= ChNine);
  always_comb begin
    is_hex = 1'b1;
    nib = 4'd0;
    if (is_dig) begin
      nib = 4'(ch - ChZero);
    end else if ((ch >= ChUpA) && (ch <= ChUpF)) begin
      nib = 4'(ch - ChUpA + 8'd10);
    end else if ((ch >= ChLowA) && (ch <= ChLowF)) begin
      nib = 4'(ch - ChLowA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Token recognizer.
  always_comb begin
    mode_d = mode_q;
    acc_d = acc_q;
    emit_req = 1'b0;
    emit_val = acc_q;
    nul_fin = 1'b0;
    unique case (mode_q)
      ModeZero: begin
        if ((ch == ChLowX) || (ch == ChUpX)) begin
          acc_d = 8'd0;
          mode_d = ModeHex;
        end else if (is_dig) begin
          acc_d = ch - ChZero;
          mode_d = ModeDec;
        end else begin
          emit_req = 1'b1;
          emit_val = 8'd0;
          acc_d = 8'd0;
          mode_d = ModeIdle;
          nul_fin = (ch == ChNul);
        end
      end
      ModeDec: begin
        if (is_dig) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + (ch - ChZero);
        end else begin
          emit_req = 1'b1;
          acc_d = 8'd0;
          mode_d = ModeIdle;
          nul_fin = (ch == ChNul);
        end
      end
      ModeHex: begin
        if (is_hex) begin
          acc_d = {acc_q[3:0], nib};
        end else begin
          emit_req = 1'b1;
          acc_d = 8'd0;
          mode_d = ModeIdle;
          nul_fin = (ch == ChNul);
        end
      end
      ModeSwallow: begin
        mode_d = ModeIdle;
        nul_fin = (ch == ChNul);
      end
      default: begin
        mode_d = ModeIdle;
        if (ch == ChNul) begin
          nul_fin = 1'b1;
        end else if (ch == ChZero) begin
          acc_d = 8'd0;
          mode_d = ModeZero;
        end else if (is_dig) begin
          acc_d = ch - ChZero;
          mode_d = ModeDec;
        end else if (ch == ChComma) begin
          acc_d = 8'd0;
          mode_d = ModeSwallow;
          emit_req = 1'b1;
          emit_val = 8'd0;
        end
      end
    endcase
  end

  // Byte placement: clamp the size, wrap a stale column, then advance.
  always_comb begin
    w_eff = ({{(DimCmpW-CfgDataW){1'b0}}, width_q} > DimCmpW'(MAX_DIMENSION)) ?
            EffW'(MAX_DIMENSION) : EffW'(width_q);
    h_eff = ({{(DimCmpW-CfgDataW){1'b0}}, height_q} > DimCmpW'(MAX_DIMENSION)) ?
            EffW'(MAX_DIMENSION) : EffW'(height_q);
    w_plus = {1'b0, w_eff} + (EffW+1)'(7);
    per_row = w_plus[EffW:3];
    pos_fin = 1'b0;
    pos_push = 1'b0;
    pos_done = 1'b0;
    col1 = col_q;
    row1 = row_q;
    col_d = col_q;
    row_d = row_q;
    col_next = '0;
    if ((w_eff == '0) || (h_eff == '0) || (row_q >= h_eff)) begin
      pos_fin = 1'b1;
    end else begin
      if ({1'b0, col_q} >= per_row) begin
        col1 = '0;
        row1 = row_q + EffW'(1);
      end
      if (row1 >= h_eff) begin
        pos_fin = 1'b1;
        col_d = col1;
        row_d = row1;
      end else begin
        pos_push = 1'b1;
        col_next = {1'b0, col1} + (ColW+1)'(1);
        if (col_next >= per_row) begin
          col_d = '0;
          row_d = row1 + EffW'(1);
          if (row_d >= h_eff) begin
            pos_fin = 1'b1;
            pos_done = 1'b1;
          end
        end else begin
          col_d = col_next[ColW-1:0];
        end
      end
    end
  end

  logic do_char;
  assign do_char = accept & (in_word_i.cmd == CmdChar) & ~fin_q;
  assign push_o = do_char & emit_req & pos_push;

  always_comb begin
    push_byte_o.col = ColOutW'(col1);
    push_byte_o.row = PixW'(row1);
    push_byte_o.val = emit_val;
    push_byte_o.done = pos_done;
  end

  assign fin_d = fin_q | nul_fin | (emit_req & pos_fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= CfgDataW'(8);
      height_q <= CfgDataW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWidth:  width_q <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        default:   width_q <= width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      acc_q <= '0;
      col_q <= '0;
      row_q <= '0;
      fin_q <= 1'b0;
    end else if (accept && (in_word_i.cmd == CmdRestart)) begin
      mode_q <= ModeIdle;
      acc_q <= '0;
      col_q <= '0;
      row_q <= '0;
      fin_q <= 1'b0;
    end else if (do_char) begin
      mode_q <= mode_d;
      acc_q <= acc_d;
      fin_q <= fin_d;
      if (emit_req) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

`ifndef SYNTHESIS
  // Once finished, no byte leaves until a restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fin_q |-> !push_o)
    else $error("byte queued after the image finished");
  // The last byte of an image always ends decoding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_byte_o.done) |=> fin_q)
    else $error("final byte did not finish the image");
`endif

endmodule

[rtl/core/xbmd_queue.sv]
// ----------------------------------------------------------------------------
// XBM decoder byte queue
// Short first-in first-out buffer of placed bytes between front and back.
// ----------------------------------------------------------------------------
module xbmd_queue import xbmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  xbmd_byte_t  push_byte_i,
  input  logic        pop_i,
  output xbmd_byte_t  head_o,
  output xbmd_qstat_t stat_o
);

  xbmd_byte_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign stat_o.full = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign head_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QueuePtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QueuePtrW+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat_o.full |-> !push_i)
    else $error("push into a full byte queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat_o.empty |-> !pop_i)
    else $error("pop from an empty byte queue");
`endif

endmodule

[rtl/core/xbmd_back.sv]
// ----------------------------------------------------------------------------
// XBM decoder back end
// Serializes each queued byte into eight pixel words, least significant first.
// ----------------------------------------------------------------------------
module xbmd_back import xbmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  xbmd_byte_t  head_i,
  input  xbmd_qstat_t q_stat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output xbmd_out_t   out_word_o
);

  logic       busy_q;
  xbmd_byte_t cur_q;
  logic [2:0] bit_q;
  logic       out_acc, last_bit;

  assign out_acc = busy_q & ~out_stall_i;
  assign last_bit = (bit_q == 3'd7);
  // Load a new byte when empty-handed or as the eighth pixel leaves.
  assign pop_o = ~q_stat_i.empty & (~busy_q | (out_acc & last_bit));

  assign out_valid_o = busy_q;
  always_comb begin
    out_word_o.pixel_x = {cur_q.col, bit_q};
    out_word_o.pixel_y = cur_q.row;
    out_word_o.pixel_on = cur_q.val[bit_q];
    out_word_o.last = last_bit;
    out_word_o.image_done = last_bit & cur_q.done;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      bit_q <= '0;
    end else if (out_acc) begin
      bit_q <= bit_q + 3'd1;
      if (last_bit) begin
        busy_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_q |-> (bit_q == 3'd0))
    else $error("pixel counter left mid-byte while idle");
`endif

endmodule

[rtl/core/xbm_text_to_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// XBM text-to-pixel decoder
// Turns the text of an XBM bits array into a stream of pixel words.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Word
//   input     in         in_valid_i/in_stall_o  xbmd_in_t  (cmd, char_code)
//   output    out        out_valid_o/out_stall_i xbmd_out_t (x, y, on, last, done)
//   config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// The front end takes one character word per cycle while the queue is not full,
// and decides in that same cycle whether it completes a byte and where that byte
// lands in the image. A completed byte enters a four-entry queue; the back end
// then sends eight pixel words, one per cycle while the output does not stall.
// The input side stalls only while the queue is full, so dense text such as
// "0,0," runs at the output's pace of eight words per two characters.
// Reset restores a width of 8 and a height of 1 and clears all position state.
// A restart word clears position and token state but keeps queued pixels.
//
module xbm_text_to_pixel_decoder import xbmd_pkg::*; #(
  parameter int MAX_DIMENSION = MaxDimensionDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xbmd_in_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xbmd_out_t           out_word_o
);

  // Front-to-queue and queue-to-back connections.
  logic        push, pop;
  xbmd_byte_t  push_byte, head;
  xbmd_qstat_t q_stat;

  // Tokenizer and byte placement.
  xbmd_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_byte_o(push_byte)
  );

  // Decouples character intake from pixel output.
  xbmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_byte_i(push_byte),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // Pixel serializer; its byte register doubles as the output register.
  xbmd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule
